@@ sv/voxel_ray_walker_3d_core_assert.svh @@
// assertion macros for the voxel ray walker
// expects clk and rst_n in the scope of the module that uses them
`ifndef VOXEL_RAY_WALKER_3D_CORE_ASSERT_SVH
`define VOXEL_RAY_WALKER_3D_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property that holds at every edge out of reset
`define VRW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define VRW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define VRW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VRW_ASSERT(lbl, prop, msg)
`define VRW_ASSERT_IMP(lbl, ante, cons, msg)
`define VRW_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/vrw_pkg.sv @@
// shared types, constants and helpers of the voxel ray walker
// no dependencies
package vrw_pkg;

    localparam int COORD_W     = 4;   // voxel index as seen on the ports
    localparam int IDX_W       = 5;   // internal index, wide enough for any bin count
    localparam int SIGNS_W     = 6;
    localparam int FIELD_W     = 32;  // distance fields on the request
    localparam int LIMIT_W     = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LIMIT_W-1:0] MAX_LIMIT = 6'd45;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_BINS_X = 2'd0,
        REG_BINS_Y = 2'd1,
        REG_BINS_Z = 2'd2
    } cfg_reg_t;

    // per-axis motion
    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_POS  = 2'd1,
        STEP_NEG  = 2'd2
    } step_t;

    typedef struct packed {
        logic [COORD_W-1:0] start_ix;
        logic [COORD_W-1:0] start_iy;
        logic [COORD_W-1:0] start_iz;
        logic [SIGNS_W-1:0] direction_signs;
        logic [FIELD_W-1:0] first_dist_x;
        logic [FIELD_W-1:0] first_dist_y;
        logic [FIELD_W-1:0] first_dist_z;
        logic [FIELD_W-1:0] delta_x;
        logic [FIELD_W-1:0] delta_y;
        logic [FIELD_W-1:0] delta_z;
        logic [LIMIT_W-1:0] step_limit;
    } ray_t;

    typedef struct packed {
        logic [COORD_W-1:0] voxel_ix;
        logic [COORD_W-1:0] voxel_iy;
        logic [COORD_W-1:0] voxel_iz;
        logic               last_voxel;
        logic               left_grid;
    } voxel_t;

    // effective bin counts, already clamped to the grid size
    typedef struct packed {
        logic [IDX_W-1:0] nx;
        logic [IDX_W-1:0] ny;
        logic [IDX_W-1:0] nz;
    } grid_t;

    // classified ray as it sits in the queue
    typedef struct packed {
        logic [COORD_W-1:0] start_ix;
        logic [COORD_W-1:0] start_iy;
        logic [COORD_W-1:0] start_iz;
        step_t              sx;
        step_t              sy;
        step_t              sz;
        logic [FIELD_W-1:0] first_dist_x;
        logic [FIELD_W-1:0] first_dist_y;
        logic [FIELD_W-1:0] first_dist_z;
        logic [FIELD_W-1:0] delta_x;
        logic [FIELD_W-1:0] delta_y;
        logic [FIELD_W-1:0] delta_z;
        logic [LIMIT_W-1:0] limit;
        logic               outside;
    } ray_item_t;

    // code three means no motion
    function automatic step_t decode_step(input logic [1:0] code);
        step_t s;
        case (code)
            STEP_POS: s = STEP_POS;
            STEP_NEG: s = STEP_NEG;
            default:  s = STEP_NONE;
        endcase
        return s;
    endfunction

endpackage

@@ sv/vrw_front.sv @@
// front end: takes a ray request, decodes signs, clamps the limit, checks the start voxel
// depends on vrw_pkg
module vrw_front #(
    parameter int DIST_WIDTH = 32
) (
    input  logic              ray_valid,
    output logic              ray_stall,
    input  vrw_pkg::ray_t     ray,
    input  vrw_pkg::grid_t    grid,
    input  logic              full,
    output logic              push,
    output vrw_pkg::ray_item_t item
);
    import vrw_pkg::*;

    // distances are taken in their low DIST_WIDTH bits
    localparam logic [63:0] MASK64 = (64'd1 << DIST_WIDTH) - 64'd1;
    localparam logic [FIELD_W-1:0] FIELD_MASK = MASK64[FIELD_W-1:0];

    assign ray_stall = full;
    assign push      = ray_valid && !full;

    always_comb
    begin
        item.start_ix     = ray.start_ix;
        item.start_iy     = ray.start_iy;
        item.start_iz     = ray.start_iz;
        item.sx           = decode_step(ray.direction_signs[1:0]);
        item.sy           = decode_step(ray.direction_signs[3:2]);
        item.sz           = decode_step(ray.direction_signs[5:4]);
        item.first_dist_x = ray.first_dist_x & FIELD_MASK;
        item.first_dist_y = ray.first_dist_y & FIELD_MASK;
        item.first_dist_z = ray.first_dist_z & FIELD_MASK;
        item.delta_x      = ray.delta_x & FIELD_MASK;
        item.delta_y      = ray.delta_y & FIELD_MASK;
        item.delta_z      = ray.delta_z & FIELD_MASK;
        item.limit        = (ray.step_limit > MAX_LIMIT) ? MAX_LIMIT : ray.step_limit;
        // zero bins or a start beyond the grid
        item.outside      = ({1'b0, ray.start_ix} >= grid.nx)
                         || ({1'b0, ray.start_iy} >= grid.ny)
                         || ({1'b0, ray.start_iz} >= grid.nz);
    end

endmodule

@@ sv/vrw_queue.sv @@
// short fifo of classified rays between front end and walker
// depends on vrw_pkg and the assertion header
`include "voxel_ray_walker_3d_core_assert.svh"
module vrw_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  vrw_pkg::ray_item_t item,
    output logic               full,
    input  logic               pop,
    output logic               avail,
    output vrw_pkg::ray_item_t head
);
    import vrw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    ray_item_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == DEPTH_CNT);
    assign avail = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= item;
    end

    `VRW_ASSERT(a_count_bound, count_reg <= DEPTH_CNT, "queue count above depth")
    `VRW_ASSERT_IMP(a_no_push_full, count_reg == DEPTH_CNT, !push, "push into full queue")
    `VRW_ASSERT_IMP(a_no_pop_empty, count_reg == '0, !pop, "pop from empty queue")

endmodule

@@ sv/vrw_walker.sv @@
// back end: walks one ray through the grid, one voxel per unstalled cycle into an output register
// depends on vrw_pkg and the assertion header
`include "voxel_ray_walker_3d_core_assert.svh"
module vrw_walker #(
    parameter int DIST_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vrw_pkg::ray_item_t head,
    input  logic               avail,
    output logic               pop,
    input  vrw_pkg::grid_t     grid,
    output logic               voxel_valid,
    input  logic               voxel_stall,
    output vrw_pkg::voxel_t    voxel
);
    import vrw_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef logic [DIST_WIDTH-1:0] dist_t;

    function automatic dist_t sat_add(input dist_t a, input dist_t b);
        logic [DIST_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        if ((&a) || (&b) || s[DIST_WIDTH])
            return '1;
        return s[DIST_WIDTH-1:0];
    endfunction

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    step_t              sx_reg, sx_next, sy_reg, sy_next, sz_reg, sz_next;
    dist_t              tx_reg, tx_next, ty_reg, ty_next, tz_reg, tz_next;
    dist_t              dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [LIMIT_W-1:0] k_reg, k_next, lim_reg, lim_next;
    logic               out_valid_reg, out_valid_next;
    voxel_t             out_reg, out_next;

    logic             ld_ok;
    logic             sel_x, sel_y;
    dist_t            t_sel, d_sel, t_sum;
    logic [IDX_W-1:0] idx_sel, bins_sel, idx_new;
    step_t            s_sel;
    logic             leave, done_cnt;

    assign voxel_valid = out_valid_reg;
    assign voxel       = out_reg;
    assign ld_ok       = !out_valid_reg || !voxel_stall;

    // axis choice, ties go to z over y and to y over x
    always_comb
    begin
        sel_x = (tx_reg < ty_reg) && (tx_reg < tz_reg);
        sel_y = !sel_x && (ty_reg < tz_reg);
        if (sel_x)
        begin
            t_sel = tx_reg; d_sel = dx_reg; idx_sel = cx_reg; s_sel = sx_reg;
            bins_sel = grid.nx;
        end
        else if (sel_y)
        begin
            t_sel = ty_reg; d_sel = dy_reg; idx_sel = cy_reg; s_sel = sy_reg;
            bins_sel = grid.ny;
        end
        else
        begin
            t_sel = tz_reg; d_sel = dz_reg; idx_sel = cz_reg; s_sel = sz_reg;
            bins_sel = grid.nz;
        end
        t_sum = sat_add(t_sel, d_sel);
        case (s_sel)
            STEP_POS:
            begin
                idx_new = idx_sel + 1'b1;
                leave   = ({1'b0, idx_sel} + 6'd1) >= {1'b0, bins_sel};
            end
            STEP_NEG:
            begin
                idx_new = idx_sel - 1'b1;
                leave   = (idx_sel == '0);
            end
            default:
            begin
                idx_new = idx_sel;
                leave   = 1'b0;
            end
        endcase
        done_cnt = (k_reg == lim_reg + 6'd1);
    end

    always_comb
    begin
        state_next     = state_reg;
        cx_next = cx_reg; cy_next = cy_reg; cz_next = cz_reg;
        sx_next = sx_reg; sy_next = sy_reg; sz_next = sz_reg;
        tx_next = tx_reg; ty_next = ty_reg; tz_next = tz_reg;
        dx_next = dx_reg; dy_next = dy_reg; dz_next = dz_reg;
        k_next         = k_reg;
        lim_next       = lim_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && voxel_stall;
        pop            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (avail)
                begin
                    if (head.outside)
                    begin
                        // start voxel alone, marked as leaving
                        if (ld_ok)
                        begin
                            pop                 = 1'b1;
                            out_valid_next      = 1'b1;
                            out_next.voxel_ix   = head.start_ix;
                            out_next.voxel_iy   = head.start_iy;
                            out_next.voxel_iz   = head.start_iz;
                            out_next.last_voxel = 1'b1;
                            out_next.left_grid  = 1'b1;
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        cx_next    = IDX_W'(head.start_ix);
                        cy_next    = IDX_W'(head.start_iy);
                        cz_next    = IDX_W'(head.start_iz);
                        sx_next    = head.sx;
                        sy_next    = head.sy;
                        sz_next    = head.sz;
                        tx_next    = DIST_WIDTH'(head.first_dist_x);
                        ty_next    = DIST_WIDTH'(head.first_dist_y);
                        tz_next    = DIST_WIDTH'(head.first_dist_z);
                        dx_next    = DIST_WIDTH'(head.delta_x);
                        dy_next    = DIST_WIDTH'(head.delta_y);
                        dz_next    = DIST_WIDTH'(head.delta_z);
                        k_next     = '0;
                        lim_next   = head.limit;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                // emit current voxel, knowing whether the next step ends the walk
                if (ld_ok)
                begin
                    out_valid_next      = 1'b1;
                    out_next.voxel_ix   = cx_reg[COORD_W-1:0];
                    out_next.voxel_iy   = cy_reg[COORD_W-1:0];
                    out_next.voxel_iz   = cz_reg[COORD_W-1:0];
                    out_next.last_voxel = done_cnt || leave;
                    out_next.left_grid  = !done_cnt && leave;
                    if (done_cnt || leave)
                        state_next = ST_IDLE;
                    else
                    begin
                        k_next = k_reg + 1'b1;
                        if (sel_x)
                        begin
                            tx_next = t_sum; cx_next = idx_new;
                        end
                        else if (sel_y)
                        begin
                            ty_next = t_sum; cy_next = idx_new;
                        end
                        else
                        begin
                            tz_next = t_sum; cz_next = idx_new;
                        end
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            cx_reg  <= '0;         cy_reg  <= '0;         cz_reg  <= '0;
            sx_reg  <= STEP_NONE;  sy_reg  <= STEP_NONE;  sz_reg  <= STEP_NONE;
            tx_reg  <= '0;         ty_reg  <= '0;         tz_reg  <= '0;
            dx_reg  <= '0;         dy_reg  <= '0;         dz_reg  <= '0;
            k_reg   <= '0;
            lim_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            cx_reg  <= cx_next;  cy_reg  <= cy_next;  cz_reg  <= cz_next;
            sx_reg  <= sx_next;  sy_reg  <= sy_next;  sz_reg  <= sz_next;
            tx_reg  <= tx_next;  ty_reg  <= ty_next;  tz_reg  <= tz_next;
            dx_reg  <= dx_next;  dy_reg  <= dy_next;  dz_reg  <= dz_next;
            k_reg   <= k_next;
            lim_reg <= lim_next;
        end
    end

    `VRW_ASSERT_IMP(a_pop_needs_item, pop, avail, "walker popped an empty queue")
    `VRW_ASSERT_IMP(a_step_bound, state_reg == ST_WALK, k_reg <= lim_reg + 6'd1, "step count overrun")
    `VRW_ASSERT_IMP(a_limit_clamped, state_reg == ST_WALK, lim_reg <= MAX_LIMIT, "limit not clamped")
    `VRW_ASSERT_IMP(a_left_on_last, out_valid_reg && out_reg.left_grid, out_reg.last_voxel, "left_grid without last_voxel")

endmodule

@@ sv/voxel_ray_walker_3d_core.sv @@
// voxel ray walker top level: bin registers, front end, ray queue and walker
// depends on vrw_pkg, vrw_front, vrw_queue and vrw_walker
//
// grid traversal of one prepared ray per request. a request carries the
// start voxel, per-axis direction signs, the first-boundary distances and
// per-voxel increments (unsigned 16.16, all ones is infinity) and a step
// limit. the block returns the start voxel and every voxel the ray enters,
// one result per cycle while the output is not stalled, and flags the final
// voxel with last_voxel; on that voxel left_grid tells a walk that left the
// grid from one cut off by the limit. the front end classifies a request in
// the cycle it is accepted and drops it into a two-entry queue, so requests
// keep being taken while a ray is being walked. the walker loads a ray with
// no result, then gives one voxel per step; the limit is clamped to 45,
// and a ray that starts outside the grid gives its single result with no
// load step. the rate is set by the walker's single compare-and-add step,
// one axis advance per cycle while the result is not stalled; each result
// sits in one output register and the walker holds for as long as that
// result is stalled. the user must write bin counts through the cfg port
// only while no ray is in flight; the block itself does not enforce this.
module voxel_ray_walker_3d_core #(
    parameter int GRID_SIZE  = 16,
    parameter int DIST_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    // configuration write port
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [4:0]       cfg_data,
    // ray requests
    input  logic             ray_valid,
    output logic             ray_stall,
    input  vrw_pkg::ray_t    ray,
    // voxel results
    output logic             voxel_valid,
    input  logic             voxel_stall,
    output vrw_pkg::voxel_t  voxel
);
    import vrw_pkg::*;

    // bin counts above the grid size act as the grid size
    localparam logic [IDX_W-1:0] GRID_LIMIT = IDX_W'(GRID_SIZE);

    // bin count registers, reset to 16
    logic [IDX_W-1:0] bins_x_reg, bins_y_reg, bins_z_reg;

    grid_t     grid;
    logic      full, push, pop, avail;
    ray_item_t item, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_x_reg <= 5'd16;
            bins_y_reg <= 5'd16;
            bins_z_reg <= 5'd16;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BINS_X: bins_x_reg <= cfg_data;
                REG_BINS_Y: bins_y_reg <= cfg_data;
                REG_BINS_Z: bins_z_reg <= cfg_data;
                default:    ;   // unused index, write dropped
            endcase
        end
    end

    // effective grid seen by the front end and the walker
    always_comb
    begin
        grid.nx = (bins_x_reg > GRID_LIMIT) ? GRID_LIMIT : bins_x_reg;
        grid.ny = (bins_y_reg > GRID_LIMIT) ? GRID_LIMIT : bins_y_reg;
        grid.nz = (bins_z_reg > GRID_LIMIT) ? GRID_LIMIT : bins_z_reg;
    end

    // request intake and classification
    vrw_front #(
        .DIST_WIDTH (DIST_WIDTH)
    ) u_front (
        .ray_valid (ray_valid),
        .ray_stall (ray_stall),
        .ray       (ray),
        .grid      (grid),
        .full      (full),
        .push      (push),
        .item      (item)
    );

    // decouples intake from the walk
    vrw_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .full  (full),
        .pop   (pop),
        .avail (avail),
        .head  (head)
    );

    // per-step traversal and result register
    vrw_walker #(
        .DIST_WIDTH (DIST_WIDTH)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .avail       (avail),
        .pop         (pop),
        .grid        (grid),
        .voxel_valid (voxel_valid),
        .voxel_stall (voxel_stall),
        .voxel       (voxel)
    );

endmodule

@@ test/voxel_ray_walker_3d_core_test.sv @@
// self-checking testbench for voxel_ray_walker_3d_core: directed rays, then random rays
// under varying grid sizes and handshake pressure, checked against a grid traversal model
// depends on vrw_pkg and voxel_ray_walker_3d_core
module voxel_ray_walker_3d_core_test;

    import vrw_pkg::*;

    localparam int          GRID        = 16;
    localparam int          QUIET_LIMIT = 4000;
    localparam int          HOLD_OFF    = 400;
    localparam logic [1:0]  SIGN_HOLD   = 2'd3;     // undefined sign code, acts as no motion
    localparam logic [31:0] INF         = 32'hFFFF_FFFF;
    localparam logic [31:0] ONE         = 32'h0001_0000;
    localparam logic [31:0] HALF        = 32'h0000_8000;
    localparam voxel_t      NO_WANT     = '0;

    // one row of the directed table
    typedef struct {
        bit         regrid;
        logic [4:0] gx;
        logic [4:0] gy;
        logic [4:0] gz;
        ray_t       ray;
        bit         typed;
        voxel_t     want;
    } ray_case_t;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   cfg_write   = 1'b0;
    logic   [1:0] cfg_index = REG_BINS_X;
    logic   [4:0] cfg_data  = '0;
    logic   ray_valid   = 1'b0;
    logic   ray_stall;
    ray_t   ray         = '0;
    logic   voxel_valid;
    logic   voxel_stall = 1'b0;
    voxel_t voxel;

    // bin counts as last written
    logic [4:0] grid_x = 5'd16;
    logic [4:0] grid_y = 5'd16;
    logic [4:0] grid_z = 5'd16;

    voxel_t    expected_voxels [$];
    voxel_t    want;
    ray_case_t directed_rows [$];
    int        error_count   = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_cycles   = 0;
    int        quiet_cycles  = 0;

    voxel_ray_walker_3d_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .ray_valid   (ray_valid),
        .ray_stall   (ray_stall),
        .ray         (ray),
        .voxel_valid (voxel_valid),
        .voxel_stall (voxel_stall),
        .voxel       (voxel)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // traversal model
    // ---------------------------------------------------------------

    // bin count as the walker sees it
    function automatic int grid_span(logic [4:0] b);
        return (b > GRID) ? GRID : int'(b);
    endfunction

    function automatic int axis_step(logic [1:0] code);
        if (code == STEP_POS)
            return 1;
        if (code == STEP_NEG)
            return -1;
        return 0;
    endfunction

    // saturating distance add, infinity absorbs everything
    function automatic logic [31:0] dist_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        if (a == INF || b == INF)
            return INF;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? INF : s[31:0];
    endfunction

    // plain voxel, not yet marked as last
    function automatic voxel_t mk_voxel(int ix, int iy, int iz);
        voxel_t v;
        v.voxel_ix   = 4'(ix);
        v.voxel_iy   = 4'(iy);
        v.voxel_iz   = 4'(iz);
        v.last_voxel = 1'b0;
        v.left_grid  = 1'b0;
        return v;
    endfunction

    // append to the scoreboard
    function automatic void queue_expected(voxel_t v);
        expected_voxels = {expected_voxels, v};
    endfunction

    // walk one ray and queue every voxel it should produce
    function automatic void trace_ray(ray_t r);
        int          nx, ny, nz, ix, iy, iz, sx, sy, sz, lim;
        logic [31:0] tx, ty, tz;
        bit          left, off_grid;
        voxel_t      path [$];
        nx = grid_span(grid_x);
        ny = grid_span(grid_y);
        nz = grid_span(grid_z);
        ix = r.start_ix;
        iy = r.start_iy;
        iz = r.start_iz;
        sx = axis_step(r.direction_signs[1:0]);
        sy = axis_step(r.direction_signs[3:2]);
        sz = axis_step(r.direction_signs[5:4]);
        tx = r.first_dist_x;
        ty = r.first_dist_y;
        tz = r.first_dist_z;
        lim = r.step_limit;
        if (lim > MAX_LIMIT)
            lim = MAX_LIMIT;
        left = 1'b0;
        path = {path, mk_voxel(ix, iy, iz)};
        if (ix >= nx || iy >= ny || iz >= nz)
            left = 1'b1;
        else
        begin
            for (int s = 0; s <= lim; s++)
            begin
                // strictly smallest wins, ties go to z over y and to y over x
                if (tx < ty && tx < tz)
                begin
                    tx = dist_add(tx, r.delta_x);
                    ix += sx;
                    off_grid = (ix < 0 || ix >= nx);
                end
                else if (ty < tz)
                begin
                    ty = dist_add(ty, r.delta_y);
                    iy += sy;
                    off_grid = (iy < 0 || iy >= ny);
                end
                else
                begin
                    tz = dist_add(tz, r.delta_z);
                    iz += sz;
                    off_grid = (iz < 0 || iz >= nz);
                end
                if (off_grid)
                begin
                    left = 1'b1;
                    break;
                end
                path = {path, mk_voxel(ix, iy, iz)};
            end
        end
        path[path.size()-1].last_voxel = 1'b1;
        path[path.size()-1].left_grid  = left;
        foreach (path[i])
            queue_expected(path[i]);
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic ray_t mk_ray(logic [3:0] ix, logic [3:0] iy, logic [3:0] iz,
                                    logic [5:0] signs,
                                    logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                                    logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                    logic [5:0] lim);
        ray_t r;
        r.start_ix        = ix;
        r.start_iy        = iy;
        r.start_iz        = iz;
        r.direction_signs = signs;
        r.first_dist_x    = tx;
        r.first_dist_y    = ty;
        r.first_dist_z    = tz;
        r.delta_x         = dx;
        r.delta_y         = dy;
        r.delta_z         = dz;
        r.step_limit      = lim;
        return r;
    endfunction

    // mostly real directions, a few still axes and the odd undefined code
    function automatic logic [1:0] pick_sign();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return STEP_POS;
        if (p < 90)
            return STEP_NEG;
        if (p < 97)
            return STEP_NONE;
        return SIGN_HOLD;
    endfunction

    function automatic logic [31:0] pick_dist();
        if ($urandom_range(0, 99) < 5)
            return INF;
        return $urandom_range(32'h0000_0100, 32'h0003_0000);
    endfunction

    // most rays start inside the grid with sane distances so that walks run long
    function automatic ray_t random_ray();
        ray_t r;
        r = mk_ray(4'($urandom), 4'($urandom), 4'($urandom), 6'($urandom),
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   6'($urandom));
        if ($urandom_range(0, 99) < 80)
        begin
            if (grid_x != 0)
                r.start_ix = 4'($urandom_range(0, grid_span(grid_x) - 1));
            if (grid_y != 0)
                r.start_iy = 4'($urandom_range(0, grid_span(grid_y) - 1));
            if (grid_z != 0)
                r.start_iz = 4'($urandom_range(0, grid_span(grid_z) - 1));
            r.direction_signs = {pick_sign(), pick_sign(), pick_sign()};
            r.first_dist_x    = pick_dist();
            r.first_dist_y    = pick_dist();
            r.first_dist_z    = pick_dist();
            r.delta_x         = pick_dist();
            r.delta_y         = pick_dist();
            r.delta_z         = pick_dist();
        end
        return r;
    endfunction

    // offer one request and hold it until taken
    task automatic send_ray(ray_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            ray_valid <= 1'b0;
            @(posedge clk);
        end
        ray_valid <= 1'b1;
        ray       <= r;
        @(posedge clk);
        while (ray_stall)
            @(posedge clk);
    endtask

    // stop sending and let every outstanding voxel come out
    task automatic settle();
        ray_valid <= 1'b0;
        while (expected_voxels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_grid(logic [4:0] x, logic [4:0] y, logic [4:0] z);
        cfg_reg_t   regs [3];
        logic [4:0] vals [3];
        regs = '{REG_BINS_X, REG_BINS_Y, REG_BINS_Z};
        vals = '{x, y, z};
        settle();
        for (int i = 0; i < 3; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        grid_x = x;
        grid_y = y;
        grid_z = z;
    endtask

    task automatic check_field(string name, logic [3:0] exp_val, logic [3:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            error_count++;
        end
    endtask

    // ---------------------------------------------------------------
    // result side: random stall, or a long hold-off when asked for
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            voxel_stall <= 1'b1;
            hold_cycles--;
        end
        else
            voxel_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // compare each taken voxel with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && voxel_valid && !voxel_stall)
        begin
            if (expected_voxels.size() == 0)
            begin
                $error("voxel with nothing expected: %p", voxel);
                error_count++;
            end
            else
            begin
                want = expected_voxels.pop_front();
                check_field("voxel_ix", want.voxel_ix, voxel.voxel_ix);
                check_field("voxel_iy", want.voxel_iy, voxel.voxel_iy);
                check_field("voxel_iz", want.voxel_iz, voxel.voxel_iz);
                check_field("last_voxel", 4'(want.last_voxel), 4'(voxel.last_voxel));
                check_field("left_grid", 4'(want.left_grid), 4'(voxel.left_grid));
            end
        end
    end

    // watchdog: too long without any handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((ray_valid && !ray_stall) || (voxel_valid && !voxel_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("voxel_ray_walker_3d_core_test NOT OK");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        ray_t      r;
        logic [4:0] plan [9][3];

        // directed rays; typed rows are single-voxel walks read straight off the rules
        directed_rows = '{
            // everything zero, still axes: start voxel twice, ended by the limit
            '{0, 0, 0, 0, mk_ray(0, 0, 0, {STEP_NONE, STEP_NONE, STEP_NONE},
                                 0, 0, 0, 0, 0, 0, 0), 0, NO_WANT},
            // straight x walk across the whole grid and out
            '{0, 0, 0, 0, mk_ray(0, 5, 5, {STEP_NONE, STEP_NONE, STEP_POS},
                                 HALF, INF, INF, ONE, ONE, ONE, 45), 0, NO_WANT},
            // first step leaves through the high x face
            '{0, 0, 0, 0, mk_ray(15, 0, 0, {STEP_NONE, STEP_NONE, STEP_POS},
                                 0, INF, INF, ONE, ONE, ONE, 10),
              1, '{4'd15, 4'd0, 4'd0, 1'b1, 1'b1}},
            // first step leaves through the low y face
            '{0, 0, 0, 0, mk_ray(6, 0, 9, {STEP_NONE, STEP_NEG, STEP_NONE},
                                 INF, 0, INF, ONE, ONE, ONE, 10),
              1, '{4'd6, 4'd0, 4'd9, 1'b1, 1'b1}},
            // three-way tie goes to z, which leaves at once
            '{0, 0, 0, 0, mk_ray(2, 4, 15, {STEP_POS, STEP_NONE, STEP_NONE},
                                 ONE, ONE, ONE, ONE, ONE, ONE, 3),
              1, '{4'd2, 4'd4, 4'd15, 1'b1, 1'b1}},
            // undefined sign code everywhere, limit above the clamp
            '{0, 0, 0, 0, mk_ray(8, 8, 8, {SIGN_HOLD, SIGN_HOLD, SIGN_HOLD},
                                 32'h1234_5678, 32'h0000_0001, 32'hFFFF_FFFE,
                                 ONE, HALF, ONE, 63), 0, NO_WANT},
            // diagonal from the corner with equal distances
            '{0, 0, 0, 0, mk_ray(0, 0, 0, {STEP_POS, STEP_POS, STEP_POS},
                                 ONE, ONE, ONE, ONE, ONE, ONE, 45), 0, NO_WANT},
            // x and y tied below z
            '{0, 0, 0, 0, mk_ray(3, 3, 3, {STEP_POS, STEP_POS, STEP_POS},
                                 ONE, ONE, 32'h0002_0000, HALF, HALF, HALF, 5), 0, NO_WANT},
            // sums that overflow into infinity
            '{0, 0, 0, 0, mk_ray(4, 4, 4, {STEP_NEG, STEP_POS, STEP_POS},
                                 32'hFFFF_0000, 32'hFFFF_8000, INF,
                                 32'h0002_0000, 32'h7FFF_FFFF, ONE, 20), 0, NO_WANT},
            // infinite increments on every axis
            '{0, 0, 0, 0, mk_ray(7, 7, 7, {STEP_NEG, STEP_NEG, STEP_NEG},
                                 0, 0, 0, INF, INF, INF, 45), 0, NO_WANT},
            // negative x walk out through the low face
            '{0, 0, 0, 0, mk_ray(15, 8, 8, {STEP_NONE, STEP_NONE, STEP_NEG},
                                 HALF, INF, INF, ONE, INF, INF, 45), 0, NO_WANT},
            // every field at all ones
            '{0, 0, 0, 0, mk_ray(15, 15, 15, 6'h3F, INF, INF, INF, INF, INF, INF, 63),
              0, NO_WANT},
            // zero x bins: every start is outside
            '{1, 0, 16, 16, mk_ray(0, 0, 0, {STEP_POS, STEP_POS, STEP_POS},
                                   ONE, ONE, ONE, ONE, ONE, ONE, 45),
              1, '{4'd0, 4'd0, 4'd0, 1'b1, 1'b1}},
            // bin counts above the grid size are clamped
            '{1, 31, 31, 31, mk_ray(0, 15, 15, {STEP_POS, STEP_NEG, STEP_NEG},
                                    HALF, ONE, ONE, ONE, ONE, ONE, 45), 0, NO_WANT},
            // one-voxel grid, leaves on the first step
            '{1, 1, 1, 1, mk_ray(0, 0, 0, {STEP_NONE, STEP_NONE, STEP_POS},
                                 0, INF, INF, ONE, ONE, ONE, 5),
              1, '{4'd0, 4'd0, 4'd0, 1'b1, 1'b1}},
            // start beyond the one-voxel grid
            '{0, 0, 0, 0, mk_ray(1, 0, 0, {STEP_NONE, STEP_NONE, STEP_POS},
                                 0, INF, INF, ONE, ONE, ONE, 5),
              1, '{4'd1, 4'd0, 4'd0, 1'b1, 1'b1}},
            // uneven grid, start outside on z only
            '{1, 4, 16, 2, mk_ray(3, 7, 2, {STEP_NEG, STEP_POS, STEP_NEG},
                                  HALF, HALF, HALF, ONE, ONE, ONE, 45),
              1, '{4'd3, 4'd7, 4'd2, 1'b1, 1'b1}},
            '{0, 0, 0, 0, mk_ray(3, 7, 1, {STEP_NEG, STEP_POS, STEP_NEG},
                                 HALF, 32'h0000_C000, ONE,
                                 ONE, 32'h0000_6000, 32'h0003_0000, 45), 0, NO_WANT},
            // back to the full grid, walk down from the far corner
            '{1, 16, 16, 16, mk_ray(15, 15, 15, {STEP_NEG, STEP_NEG, STEP_NEG},
                                    32'h0000_4000, HALF, 32'h0000_C000,
                                    ONE, ONE, ONE, 45), 0, NO_WANT}
        };

        plan = '{
            '{5'd16, 5'd16, 5'd16}, '{5'd31, 5'd31, 5'd31}, '{5'd1, 5'd1, 5'd1},
            '{5'd5, 5'd9, 5'd3},    '{5'd0, 5'd7, 5'd7},    '{5'd16, 5'd2, 5'd16},
            '{5'd0, 5'd0, 5'd0},    '{5'd0, 5'd0, 5'd0},    '{5'd0, 5'd0, 5'd0}
        };
        for (int p = 6; p < 9; p++)
            for (int a = 0; a < 3; a++)
                plan[p][a] = 5'($urandom_range(1, 31));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs without idling
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].regrid)
                set_grid(directed_rows[i].gx, directed_rows[i].gy, directed_rows[i].gz);
            send_ray(directed_rows[i].ray);
            if (directed_rows[i].typed)
                queue_expected(directed_rows[i].want);
            else
                trace_ray(directed_rows[i].ray);
        end

        // random part: three idling modes, three grid settings each
        for (int phase = 0; phase < 9; phase++)
        begin
            set_grid(plan[phase][0], plan[phase][1], plan[phase][2]);
            case (phase / 3)
                0:
                begin
                    send_idle_pct = 13;
                    recv_idle_pct = 64;
                end
                1:
                begin
                    send_idle_pct = 64;
                    recv_idle_pct = 13;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // long hold-off on the result side so the request side backs up
            if (phase == 0)
                hold_cycles = HOLD_OFF;
            for (int i = 0; i < 27; i++)
            begin
                // sender pauses mid-phase until the block has drained
                if (phase == 4 && i == 14)
                    settle();
                r = random_ray();
                send_ray(r);
                trace_ray(r);
            end
        end

        settle();
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("voxel_ray_walker_3d_core_test OK");
        else
            $display("voxel_ray_walker_3d_core_test NOT OK");
        $finish;
    end

endmodule

@@ voxel_ray_walker_3d_core.f @@
+incdir+sv
sv/vrw_pkg.sv
sv/vrw_front.sv
sv/vrw_queue.sv
sv/vrw_walker.sv
sv/voxel_ray_walker_3d_core.sv
test/voxel_ray_walker_3d_core_test.sv
